// ===== sv/mfnc_pkg.sv =====
// Package for the mixed-format number compare block.
// Holds kind codes, the normalized key type and the key helpers; no dependencies.
package mfnc_pkg;

    typedef enum logic [1:0] {
        KIND_U32 = 2'd0,
        KIND_S32 = 2'd1,
        KIND_F32 = 2'd2,
        KIND_F64 = 2'd3
    } t_kind;

    localparam int unsigned BITS_W  = 64;
    localparam int unsigned ORDER_W = 2;

    localparam logic signed [ORDER_W-1:0] ORD_LT = -2'sd1;
    localparam logic signed [ORDER_W-1:0] ORD_EQ = 2'sd0;
    localparam logic signed [ORDER_W-1:0] ORD_GT = 2'sd1;

    // Operand as an IEEE double: NaN flag, sign, and a 63-bit magnitude that orders like the value.
    typedef struct packed {
        logic        nan;
        logic        sign;
        logic [62:0] mag;
    } t_key;

    // Widen a single to double bits exactly; subnormals are normalized.
    function automatic logic [62:0] single_mag(input logic [30:0] f);
        logic [7:0]  e;
        logic [22:0] m;
        logic [4:0]  lz;
        logic [22:0] mn;
        logic [10:0] de;
        logic        found;
        e     = f[30:23];
        m     = f[22:0];
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 22; i >= 0; i--) begin
            if (!found && m[i]) begin
                found = 1'b1;
                lz    = 5'(22 - i);
            end
        end
        if (e == 8'hFF) begin
            single_mag = {11'h7FF, m, 29'd0};
        end else if (e != 8'd0) begin
            single_mag = {11'(e) + 11'd896, m, 29'd0};
        end else if (m == 23'd0) begin
            single_mag = 63'd0;
        end else begin
            mn = m << (lz + 5'd1);
            de = 11'd896 - 11'(lz);
            single_mag = {de, mn, 29'd0};
        end
    endfunction

    // Priority position of the top set bit of a 32-bit magnitude.
    function automatic logic [5:0] top_bit(input logic [31:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) p = 6'(i);
        end
        top_bit = p;
    endfunction

endpackage

// ===== sv/mfnc_int_conv.sv =====
// Integer-to-key converter for the mixed-format compare, two register stages.
// Stage A normalizes the magnitude, stage B rounds to single if asked. Uses mfnc_pkg.
module mfnc_int_conv (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_neg,
    input  logic [31:0]          i_mag,
    input  logic                 i_to_single,
    output mfnc_pkg::t_key       o_key
);

    logic        r_neg;
    logic [31:0] r_norm;
    logic [5:0]  r_top;
    logic        r_zero;
    logic        r_single;
    logic [5:0]  n_top;
    logic        rnd_up;
    logic [24:0] sig;
    logic [10:0] exp_d;
    logic [51:0] frac;
    mfnc_pkg::t_key r_key;
    mfnc_pkg::t_key n_key;

    assign n_top = mfnc_pkg::top_bit(i_mag);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg    <= i_neg;
            r_norm   <= i_mag << (6'd31 - n_top);
            r_top    <= n_top;
            r_zero   <= (i_mag == 32'd0);
            r_single <= i_to_single;
        end
    end

    // r_norm[31] is the leading one; keep 24 bits for single, round to nearest even.
    always_comb begin
        rnd_up = r_norm[7] && (r_norm[6:0] != 7'd0 || r_norm[8]);
        sig    = {1'b0, r_norm[31:8]} + 25'(rnd_up);
        exp_d  = 11'd1023 + 11'(r_top);
        frac   = {r_norm[30:0], 21'd0};
        if (r_single) begin
            if (sig[24]) begin
                exp_d = exp_d + 11'd1;
                frac  = 52'd0;
            end else begin
                frac  = {sig[22:0], 29'd0};
            end
        end
        n_key.nan  = 1'b0;
        n_key.sign = r_neg;
        n_key.mag  = r_zero ? 63'd0 : {exp_d, frac};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

// ===== sv/mixed_format_number_compare.sv =====
// Mixed-format three-way compare: an accepted request passes stage A, stage B and the order register to the result.
// Throughput one request per cycle; the pipeline holds in place while o_order is stalled.
// The stage timing is set by the 32-bit normalize shift and the 63-bit magnitude compare.
// Synchronous active-low reset clears only the stage valid bits; the data registers are not reset.
// Depends on mfnc_pkg and mfnc_int_conv.
module mixed_format_number_compare (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_left_kind,
    input  logic [mfnc_pkg::BITS_W-1:0]           i_left_bits,
    input  logic [1:0]                            i_right_kind,
    input  logic [mfnc_pkg::BITS_W-1:0]           i_right_bits,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [mfnc_pkg::ORDER_W-1:0]   o_order
);

    logic [2:0] r_vld;
    logic       adv;

    assign adv     = !(r_vld[2] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 3'd0;
        end else if (adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // Common kind decision and integer unpacking.
    logic ka_int, kb_int, both_u, single_mode, any_dbl;
    logic a_neg, b_neg;
    logic [31:0] a_mag, b_mag;
    logic [31:0] al, bl;

    always_comb begin
        al     = i_left_bits[31:0];
        bl     = i_right_bits[31:0];
        ka_int = (i_left_kind == mfnc_pkg::KIND_U32) || (i_left_kind == mfnc_pkg::KIND_S32);
        kb_int = (i_right_kind == mfnc_pkg::KIND_U32) || (i_right_kind == mfnc_pkg::KIND_S32);
        both_u = (i_left_kind == mfnc_pkg::KIND_U32) && (i_right_kind == mfnc_pkg::KIND_U32);
        any_dbl = (i_left_kind == mfnc_pkg::KIND_F64) || (i_right_kind == mfnc_pkg::KIND_F64);
        single_mode = !any_dbl && !(ka_int && kb_int);
        // Unsigned meets signed: read both as signed; u32 against float stays unsigned.
        a_neg = (ka_int && kb_int && !both_u && al[31])
             || (i_left_kind == mfnc_pkg::KIND_S32 && !(ka_int && kb_int) && al[31]);
        b_neg = (ka_int && kb_int && !both_u && bl[31])
             || (i_right_kind == mfnc_pkg::KIND_S32 && !(ka_int && kb_int) && bl[31]);
        a_mag = a_neg ? 32'd0 - al : al;
        b_mag = b_neg ? 32'd0 - bl : bl;
    end

    // Float keys travel alongside the converter's two stages.
    mfnc_pkg::t_key fa_key, fb_key;
    mfnc_pkg::t_key r_fa1, r_fb1, r_fa2, r_fb2;
    logic r_ia1, r_ib1, r_ia2, r_ib2;
    mfnc_pkg::t_key ia_key, ib_key;

    always_comb begin
        fa_key = '0;
        fb_key = '0;
        if (i_left_kind == mfnc_pkg::KIND_F64) begin
            fa_key.sign = i_left_bits[63];
            fa_key.mag  = i_left_bits[62:0];
        end else begin
            fa_key.sign = i_left_bits[31];
            fa_key.mag  = mfnc_pkg::single_mag(i_left_bits[30:0]);
        end
        if (i_right_kind == mfnc_pkg::KIND_F64) begin
            fb_key.sign = i_right_bits[63];
            fb_key.mag  = i_right_bits[62:0];
        end else begin
            fb_key.sign = i_right_bits[31];
            fb_key.mag  = mfnc_pkg::single_mag(i_right_bits[30:0]);
        end
        fa_key.nan = (fa_key.mag[62:52] == 11'h7FF) && (fa_key.mag[51:0] != 52'd0);
        fb_key.nan = (fb_key.mag[62:52] == 11'h7FF) && (fb_key.mag[51:0] != 52'd0);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fa1 <= fa_key;
            r_fb1 <= fb_key;
            r_ia1 <= ka_int;
            r_ib1 <= kb_int;
            r_fa2 <= r_fa1;
            r_fb2 <= r_fb1;
            r_ia2 <= r_ia1;
            r_ib2 <= r_ib1;
        end
    end

    mfnc_int_conv u_conv_a (
        .i_clk       (i_clk),
        .i_en        (adv),
        .i_neg       (a_neg),
        .i_mag       (a_mag),
        .i_to_single (single_mode),
        .o_key       (ia_key)
    );

    mfnc_int_conv u_conv_b (
        .i_clk       (i_clk),
        .i_en        (adv),
        .i_neg       (b_neg),
        .i_mag       (b_mag),
        .i_to_single (single_mode),
        .o_key       (ib_key)
    );

    // Final compare of sign-magnitude keys.
    mfnc_pkg::t_key ka, kb;
    logic a_zero, b_zero;
    logic signed [mfnc_pkg::ORDER_W-1:0] n_order;
    logic signed [mfnc_pkg::ORDER_W-1:0] r_order;

    always_comb begin
        ka     = r_ia2 ? ia_key : r_fa2;
        kb     = r_ib2 ? ib_key : r_fb2;
        a_zero = (ka.mag == 63'd0);
        b_zero = (kb.mag == 63'd0);
        if (ka.nan || kb.nan || (a_zero && b_zero)) begin
            n_order = mfnc_pkg::ORD_EQ;
        end else if (ka.sign != kb.sign) begin
            n_order = ka.sign ? mfnc_pkg::ORD_LT : mfnc_pkg::ORD_GT;
        end else if (ka.mag == kb.mag) begin
            n_order = mfnc_pkg::ORD_EQ;
        end else if ((ka.mag > kb.mag) != ka.sign) begin
            n_order = mfnc_pkg::ORD_GT;
        end else begin
            n_order = mfnc_pkg::ORD_LT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_order <= n_order;
    end

    assign o_order = r_order;

endmodule

// ===== bench/mixed_format_number_compare_test.sv =====
// Self-checking bench for mixed_format_number_compare: random and directed operand pairs.
// Predicts the order from operand bits alone; depends on mfnc_pkg and the block's RTL.
module mixed_format_number_compare_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        mfnc_pkg::t_kind lk;
        logic [63:0]     lb;
        mfnc_pkg::t_kind rk;
        logic [63:0]     rb;
    } t_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_left_kind = '0;
    logic [63:0] i_left_bits = '0;
    logic [1:0] i_right_kind = '0;
    logic [63:0] i_right_bits = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [1:0] o_order;

    t_pair pending_pairs[$];
    logic signed [1:0] expected_orders[$];
    int errors = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int holdoff = 0;
    bit holdoff_done = 0;
    int accepted = 0;

    mixed_format_number_compare dut (.*);

    always #1 i_clk = ~i_clk;

    // Double bits of an integer magnitude below 2^33.
    function automatic logic [63:0] int_dbl(input logic neg, input logic [32:0] m);
        int p;
        logic [63:0] sh;
        if (m == 0) return 64'd0;
        p = 0;
        for (int i = 0; i < 33; i++) if (m[i]) p = i;
        sh = 64'(m) << (52 - p);
        return {neg, 11'(1023 + p), sh[51:0]};
    endfunction

    function automatic logic [63:0] single_dbl(input logic [31:0] f);
        logic [7:0] e;
        logic [22:0] m;
        int p;
        logic [63:0] sh;
        e = f[30:23];
        m = f[22:0];
        if (e == 8'hFF) return {f[31], 11'h7FF, m, 29'd0};
        if (e != 0) return {f[31], 11'(int'(e) - 127 + 1023), m, 29'd0};
        if (m == 0) return {f[31], 63'd0};
        p = 0;
        for (int i = 0; i < 23; i++) if (m[i]) p = i;
        sh = 64'(m) << (52 - p);
        return {f[31], 11'(874 + p), sh[51:0]};
    endfunction

    function automatic logic [32:0] round_24(input logic [32:0] m);
        int s;
        logic [32:0] keep, rem, half;
        s = 0;
        while ((m >> s) >= 33'd16777216) s++;
        if (s == 0) return m;
        keep = m >> s;
        rem = m & ((33'd1 << s) - 1);
        half = 33'd1 << (s - 1);
        if (rem > half || (rem == half && keep[0])) keep++;
        return keep << s;
    endfunction

    // Operand as double bits; integers optionally rounded to single precision.
    function automatic logic [63:0] operand_dbl(input mfnc_pkg::t_kind k, input logic [63:0] b,
                                                input bit to_single);
        logic neg;
        logic [32:0] mag;
        neg = (k == mfnc_pkg::KIND_S32) && b[31];
        mag = neg ? 33'(-$signed({1'b1, b[31:0]})) : {1'b0, b[31:0]};
        case (k)
            mfnc_pkg::KIND_U32, mfnc_pkg::KIND_S32:
                return int_dbl(neg, to_single ? round_24(mag) : mag);
            mfnc_pkg::KIND_F32: return single_dbl(b[31:0]);
            default: return b;
        endcase
    endfunction

    function automatic logic signed [1:0] order_of(input t_pair p);
        logic [63:0] x, y;
        logic signed [64:0] sx, sy;
        logic signed [33:0] ix, iy;
        if (p.lk == mfnc_pkg::KIND_U32 && p.rk == mfnc_pkg::KIND_U32)
            return p.lb[31:0] > p.rb[31:0] ? mfnc_pkg::ORD_GT :
                   (p.lb[31:0] < p.rb[31:0] ? mfnc_pkg::ORD_LT : mfnc_pkg::ORD_EQ);
        if (p.lk inside {mfnc_pkg::KIND_U32, mfnc_pkg::KIND_S32} &&
            p.rk inside {mfnc_pkg::KIND_U32, mfnc_pkg::KIND_S32}) begin
            ix = $signed(p.lb[31:0]);
            iy = $signed(p.rb[31:0]);
            return ix > iy ? mfnc_pkg::ORD_GT : (ix < iy ? mfnc_pkg::ORD_LT : mfnc_pkg::ORD_EQ);
        end
        x = operand_dbl(p.lk, p.lb, !(p.lk == mfnc_pkg::KIND_F64 || p.rk == mfnc_pkg::KIND_F64));
        y = operand_dbl(p.rk, p.rb, !(p.lk == mfnc_pkg::KIND_F64 || p.rk == mfnc_pkg::KIND_F64));
        if ((&x[62:52] && |x[51:0]) || (&y[62:52] && |y[51:0])) return mfnc_pkg::ORD_EQ;
        sx = x[63] ? -$signed({2'b0, x[62:0]}) : $signed({2'b0, x[62:0]});
        sy = y[63] ? -$signed({2'b0, y[62:0]}) : $signed({2'b0, y[62:0]});
        return sx > sy ? mfnc_pkg::ORD_GT : (sx < sy ? mfnc_pkg::ORD_LT : mfnc_pkg::ORD_EQ);
    endfunction

    task automatic report_mismatch(input logic signed [1:0] got, input logic signed [1:0] want);
        $display("order mismatch at %0t: got %0d want %0d", $realtime, got, want);
        errors++;
    endtask

    task automatic add_pair(input mfnc_pkg::t_kind lk, input logic [63:0] lb,
                            input mfnc_pkg::t_kind rk, input logic [63:0] rb);
        t_pair p;
        p.lk = lk;
        p.lb = lb;
        p.rk = rk;
        p.rb = rb;
        pending_pairs.push_back(p);
    endtask

    function automatic logic [63:0] random_bits(input mfnc_pkg::t_kind k);
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: b[31:0] = 32'($urandom_range(0, 20)) - 32'd10;
            1: b = {$urandom, 32'($urandom_range(16777200, 16777300))};
            2: if (k == mfnc_pkg::KIND_F32) b[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               else if (k == mfnc_pkg::KIND_F64)
                   b[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
            3: if (k == mfnc_pkg::KIND_F32) b[30:23] = 8'd127 + 8'($urandom_range(0, 40));
               else if (k == mfnc_pkg::KIND_F64)
                   b[62:52] = 11'd1023 + 11'($urandom_range(0, 40));
            default: ;
        endcase
        return b;
    endfunction

    // Driver: hold a stalled request, advance after acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                t_pair p;
                p = pending_pairs.pop_front();
                i_valid <= 1'b1;
                i_left_kind <= p.lk;
                i_left_bits <= p.lb;
                i_right_kind <= p.rk;
                i_right_bits <= p.rb;
                if (pending_pairs.size() > 300 && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 9);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Predict on each accepted request.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            t_pair p;
            p.lk = mfnc_pkg::t_kind'(i_left_kind);
            p.lb = i_left_bits;
            p.rk = mfnc_pkg::t_kind'(i_right_kind);
            p.rb = i_right_bits;
            expected_orders.push_back(order_of(p));
            accepted <= accepted + 1;
        end
    end

    // Receiver stall: random bursts, one long hold-off to back up the pipeline.
    always @(posedge i_clk) begin
        if (!holdoff_done && accepted > 200) begin
            holdoff_done <= 1'b1;
            holdoff <= 80;
            i_stall <= 1'b1;
        end else if (holdoff > 0) begin
            holdoff <= holdoff - 1;
            i_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_stall <= 1'b1;
        end else if (pending_pairs.size() > 300 && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 8);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_orders.size() == 0) begin
                $display("unexpected result at %0t: %0d", $realtime, o_order);
                errors++;
            end else begin
                logic signed [1:0] want;
                want = expected_orders.pop_front();
                if (o_order !== want) report_mismatch(o_order, want);
            end
        end
    end

    initial begin
        mfnc_pkg::t_kind lk, rk;
        // Directed: extremes, high-bit garbage, zeros, NaNs, rounding ties.
        add_pair(mfnc_pkg::KIND_U32, 64'h0, mfnc_pkg::KIND_U32, 64'hFFFF_FFFF);
        add_pair(mfnc_pkg::KIND_U32, 64'hFFFF_FFFF_FFFF_FFFF,
                 mfnc_pkg::KIND_U32, 64'h0000_0000_FFFF_FFFF);
        add_pair(mfnc_pkg::KIND_S32, 64'h8000_0000, mfnc_pkg::KIND_S32, 64'h7FFF_FFFF);
        add_pair(mfnc_pkg::KIND_U32, 64'hFFFF_FFFF, mfnc_pkg::KIND_S32, 64'h0);
        add_pair(mfnc_pkg::KIND_S32, 64'hABCD_0000_8000_0000, mfnc_pkg::KIND_U32, 64'h8000_0000);
        add_pair(mfnc_pkg::KIND_F32, 64'h8000_0000, mfnc_pkg::KIND_F32, 64'h0);
        add_pair(mfnc_pkg::KIND_F64, 64'h8000_0000_0000_0000, mfnc_pkg::KIND_F64, 64'h0);
        add_pair(mfnc_pkg::KIND_F32, 64'h7FC0_0000, mfnc_pkg::KIND_F32, 64'h7FC0_0000);
        add_pair(mfnc_pkg::KIND_F32, 64'h7F80_0001, mfnc_pkg::KIND_U32, 64'h5);
        add_pair(mfnc_pkg::KIND_F64, 64'h7FF8_0000_0000_0000, mfnc_pkg::KIND_S32, 64'h0);
        add_pair(mfnc_pkg::KIND_F64, 64'hFFF0_0000_0000_0001,
                 mfnc_pkg::KIND_F64, 64'hFFF0_0000_0000_0000);
        add_pair(mfnc_pkg::KIND_F32, 64'h7F80_0000, mfnc_pkg::KIND_F64, 64'h7FEF_FFFF_FFFF_FFFF);
        add_pair(mfnc_pkg::KIND_F32, 64'hFF80_0000, mfnc_pkg::KIND_S32, 64'h8000_0000);
        add_pair(mfnc_pkg::KIND_U32, 64'd16777217, mfnc_pkg::KIND_F32, 64'h4B80_0000);
        add_pair(mfnc_pkg::KIND_U32, 64'd16777217, mfnc_pkg::KIND_F64, 64'h4170_0000_0000_0000);
        add_pair(mfnc_pkg::KIND_U32, 64'd16777219, mfnc_pkg::KIND_F32, 64'h4B80_0002);
        add_pair(mfnc_pkg::KIND_S32, 64'hFFFF_FFFF_8000_0001, mfnc_pkg::KIND_F32, 64'hCF00_0000);
        add_pair(mfnc_pkg::KIND_U32, 64'hFFFF_FFFF, mfnc_pkg::KIND_F32, 64'h4F80_0000);
        add_pair(mfnc_pkg::KIND_F32, 64'h0000_0001, mfnc_pkg::KIND_F64, 64'h36A0_0000_0000_0000);
        add_pair(mfnc_pkg::KIND_F32, 64'h8000_0001, mfnc_pkg::KIND_F32, 64'h0);
        add_pair(mfnc_pkg::KIND_F64, 64'h0000_0000_0000_0001, mfnc_pkg::KIND_U32, 64'h0);
        add_pair(mfnc_pkg::KIND_F64, 64'h41EF_FFFF_FFE0_0000, mfnc_pkg::KIND_U32, 64'hFFFF_FFFF);
        add_pair(mfnc_pkg::KIND_F32, 64'hFFFF_FFFF_3F80_0000, mfnc_pkg::KIND_S32, 64'h1);
        add_pair(mfnc_pkg::KIND_F64, 64'h3FF0_0000_0000_0000, mfnc_pkg::KIND_F32, 64'h3F80_0000);
        for (int n = 0; n < 1900; n++) begin
            logic [63:0] lb, rb;
            lk = mfnc_pkg::t_kind'($urandom_range(0, 3));
            rk = mfnc_pkg::t_kind'($urandom_range(0, 3));
            lb = random_bits(lk);
            rb = random_bits(rk);
            if ($urandom_range(0, 3) == 0) begin
                rk = lk;
                rb = lb ^ 64'($urandom_range(0, 1));
            end
            add_pair(lk, lb, rk, rb);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_pairs.size() > 0 || i_valid || expected_orders.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (errors == 0 && expected_orders.size() == 0)
            $display("mixed_format_number_compare: match");
        else
            $display("mixed_format_number_compare: mismatch");
        $finish;
    end

    initial begin
        #200000;
        $display("mixed_format_number_compare: mismatch");
        $finish;
    end
endmodule

// ===== files.f =====
sv/mfnc_pkg.sv
sv/mfnc_int_conv.sv
sv/mixed_format_number_compare.sv
bench/mixed_format_number_compare_test.sv
